// ===== sv/pwmc_pkg.sv =====
`default_nettype none

package pwmc_pkg;

   // field widths
   localparam int DUTY_W     = 8;
   localparam int DUTY_EXT_W = 9;
   localparam int TIME_W     = 32;
   localparam int MS_W       = 16;
   localparam int RPM_W      = 18;
   localparam int SUM_W      = 34;
   localparam int CNT_W      = 16;
   localparam int IDX_W      = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // map size default
   localparam int MAX_POINTS_DEF = 64;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PWM_FIRST     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PWM_LAST      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PWM_INCREMENT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SETTLE_MS     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_MS     = 3'd4;

   // register reset values
   localparam logic [DUTY_W-1:0] PWM_FIRST_RST     = 8'd30;
   localparam logic [DUTY_W-1:0] PWM_LAST_RST      = 8'd255;
   localparam logic [DUTY_W-1:0] PWM_INCREMENT_RST = 8'd5;
   localparam logic [MS_W-1:0]   SETTLE_MS_RST     = 16'd1500;
   localparam logic [MS_W-1:0]   SAMPLE_MS_RST     = 16'd500;

   // one result beat
   typedef struct packed {
      logic              drive_valid;
      logic [DUTY_W-1:0] drive_pwm;
      logic              point_valid;
      logic [IDX_W-1:0]  point_index;
      logic [DUTY_W-1:0] point_pwm;
      logic [RPM_W-1:0]  point_rpm;
      logic              done_res;
      logic              busy_res;
   } res_type;

   // divider request
   typedef struct packed {
      logic             start;
      logic [SUM_W-1:0] dividend;
      logic [CNT_W-1:0] divisor;
   } div_ctl_type;

   // divider status
   typedef struct packed {
      logic             busy;
      logic             done;
      logic [RPM_W-1:0] quot;
   } div_stat_type;

endpackage

`default_nettype wire

// ===== sv/pwmc_div.sv =====
`default_nettype none

module pwmc_div
   import pwmc_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire div_ctl_type  div_ctl,
   output      div_stat_type div_stat
);

   localparam int STEP_W = $clog2(SUM_W + 1);

   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  den_ff, den_in;

   logic [CNT_W:0]    rem_sh;
   logic              fits;
   logic [CNT_W:0]    rem_sub;

   // one restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      rem_sh  = {rem_ff, quo_ff[SUM_W-1]};
      fits    = rem_sh >= {1'b0, den_ff};
      rem_sub = rem_sh - {1'b0, den_ff};
   end

   // step sequencing
   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (div_ctl.start) begin
         run_in = 1'b1;
         cnt_in = STEP_W'(SUM_W);
         rem_in = '0;
         quo_in = div_ctl.dividend;
         den_in = div_ctl.divisor;
      end else if (run_ff) begin
         rem_in = fits ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
         quo_in = {quo_ff[SUM_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == STEP_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign div_stat.busy = run_ff;
   assign div_stat.done = done_ff;
   assign div_stat.quot = quo_ff[RPM_W-1:0];

endmodule

`default_nettype wire

// ===== sv/pwm_sweep_rpm_calibrator_core.sv =====
// PWM sweep calibrator: steps a motor duty from pwm_first to pwm_last and
// reports the average RPM measured at each step.
// Request channel (req_*): one beat per update or start command, carrying
// mode, the millisecond timestamp and one RPM sample. Accepted when
// req_valid is high and req_stall is low. Every request beat gives exactly
// one response beat on rsp_*, in order.
// Sequencing: one request is worked on at a time. A beat passes the idle,
// timing, evaluation and output states; one ending a step also passes the
// advance state, and one that produces a point first waits in the divide
// state for the 34-step radix-2 divider that forms the average.
// The response sits in an output register; the next request is taken while
// it waits. If rsp_stall holds it, the block finishes the following request
// and then holds req_stall high until the response register frees up.
// Configuration (csr_*): register writes, always ready, to be issued only
// while no request is in flight.
// Reset: synchronous, active high. Registers return to their defaults, the
// run is idle and no response is pending.
`default_nettype none

module pwm_sweep_rpm_calibrator_core
   import pwmc_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_valid,
   output      logic                  req_stall,
   input  wire logic                  req_mode,
   input  wire logic [TIME_W-1:0]     req_now_ms,
   input  wire logic [RPM_W-1:0]      req_rpm_sample,

   output      logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   output      logic                  rsp_drive_valid,
   output      logic [DUTY_W-1:0]     rsp_drive_pwm,
   output      logic                  rsp_point_valid,
   output      logic [IDX_W-1:0]      rsp_point_index,
   output      logic [DUTY_W-1:0]     rsp_point_pwm,
   output      logic [RPM_W-1:0]      rsp_point_rpm,
   output      logic                  rsp_done_res,
   output      logic                  rsp_busy_res,

   input  wire logic                  csr_valid,
   output      logic                  csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   localparam int PW = $clog2(MAX_POINTS + 1);

   // sequencer codes
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_TIME = 3'd1;
   localparam logic [2:0] S_EVAL = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_ADV  = 3'd4;
   localparam logic [2:0] S_OUT  = 3'd5;

   logic [2:0]            state_ff, state_in;

   // configuration registers
   logic [DUTY_W-1:0]     first_ff, first_in;
   logic [DUTY_W-1:0]     last_ff, last_in;
   logic [DUTY_W-1:0]     incr_ff, incr_in;
   logic [MS_W-1:0]       settle_ff, settle_in;
   logic [MS_W-1:0]       sample_len_ff, sample_len_in;

   // latched request beat
   logic                  mode_ff, mode_in;
   logic [TIME_W-1:0]     now_ff, now_in;
   logic [RPM_W-1:0]      rpm_ff, rpm_in;

   // window timing
   logic [TIME_W-1:0]     elapsed_ff, elapsed_in;
   logic [MS_W:0]         win_end_ff, win_end_in;

   // run state
   logic                  active_ff, active_in;
   logic [DUTY_EXT_W-1:0] duty_ff, duty_in;
   logic [TIME_W-1:0]     window_start_ff, window_start_in;
   logic [SUM_W-1:0]      total_ff, total_in;
   logic [CNT_W-1:0]      samples_ff, samples_in;
   logic [PW-1:0]         points_ff, points_in;

   // result under construction and output register
   res_type               res_ff, res_in;
   res_type               rsp_ff, rsp_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   div_ctl_type           div_ctl;
   div_stat_type          div_stat;

   pwmc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_ctl  (div_ctl),
      .div_stat (div_stat)
   );

   // configuration writes
   always_comb begin
      first_in      = first_ff;
      last_in       = last_ff;
      incr_in       = incr_ff;
      settle_in     = settle_ff;
      sample_len_in = sample_len_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PWM_FIRST:     first_in      = csr_data[DUTY_W-1:0];
            CSR_PWM_LAST:      last_in       = csr_data[DUTY_W-1:0];
            CSR_PWM_INCREMENT: incr_in       = csr_data[DUTY_W-1:0];
            CSR_SETTLE_MS:     settle_in     = csr_data;
            CSR_SAMPLE_MS:     sample_len_in = csr_data;
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in        = state_ff;
      mode_in         = mode_ff;
      now_in          = now_ff;
      rpm_in          = rpm_ff;
      elapsed_in      = elapsed_ff;
      win_end_in      = win_end_ff;
      active_in       = active_ff;
      duty_in         = duty_ff;
      window_start_in = window_start_ff;
      total_in        = total_ff;
      samples_in      = samples_ff;
      points_in       = points_ff;
      res_in          = res_ff;
      rsp_in          = rsp_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      div_ctl.start    = 1'b0;
      div_ctl.dividend = total_ff;
      div_ctl.divisor  = samples_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               mode_in  = req_mode;
               now_in   = req_now_ms;
               rpm_in   = req_rpm_sample;
               state_in = S_TIME;
            end
         end

         // wrapping elapsed time and end of the sampling window
         S_TIME: begin
            elapsed_in = now_ff - window_start_ff;
            win_end_in = {1'b0, settle_ff} + {1'b0, sample_len_ff};
            state_in   = S_EVAL;
         end

         S_EVAL: begin
            res_in   = '0;
            state_in = S_OUT;
            if (mode_ff) begin
               // start a new run
               active_in       = 1'b1;
               duty_in         = {1'b0, first_ff};
               points_in       = '0;
               window_start_in = now_ff;
               total_in        = '0;
               samples_in      = '0;
               res_in.busy_res = 1'b1;
            end else if (active_ff) begin
               res_in.drive_valid = 1'b1;
               res_in.drive_pwm   = duty_ff[DUTY_W-1:0];
               res_in.busy_res    = 1'b1;
               if (elapsed_ff < TIME_W'(settle_ff)) begin
                  // still settling
               end else if (elapsed_ff < TIME_W'(win_end_ff)) begin
                  // sampling, count saturates
                  if (samples_ff != '1) begin
                     total_in   = total_ff + SUM_W'(rpm_ff);
                     samples_in = samples_ff + 1'b1;
                  end
               end else begin
                  // step finished
                  duty_in = duty_ff + {1'b0, incr_ff};
                  if (points_ff < PW'(MAX_POINTS)) begin
                     res_in.point_valid = 1'b1;
                     res_in.point_index = IDX_W'(points_ff);
                     res_in.point_pwm   = duty_ff[DUTY_W-1:0];
                     points_in          = points_ff + 1'b1;
                     div_ctl.start      = 1'b1;
                     state_in           = S_DIV;
                  end else begin
                     state_in = S_ADV;
                  end
               end
            end
         end

         // wait for the average, zero when nothing was sampled
         S_DIV: begin
            if (div_stat.done) begin
               res_in.point_rpm = (samples_ff == '0) ? '0 : div_stat.quot;
               state_in         = S_ADV;
            end
         end

         // end of run or next window
         S_ADV: begin
            if (duty_ff > {1'b0, last_ff}) begin
               active_in        = 1'b0;
               res_in.drive_pwm = '0;
               res_in.done_res  = 1'b1;
               res_in.busy_res  = 1'b0;
            end else begin
               window_start_in = now_ff;
               total_in        = '0;
               samples_in      = '0;
            end
            state_in = S_OUT;
         end

         // hand the beat to the output register
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         first_ff        <= PWM_FIRST_RST;
         last_ff         <= PWM_LAST_RST;
         incr_ff         <= PWM_INCREMENT_RST;
         settle_ff       <= SETTLE_MS_RST;
         sample_len_ff   <= SAMPLE_MS_RST;
         active_ff       <= 1'b0;
         duty_ff         <= {1'b0, PWM_FIRST_RST};
         window_start_ff <= '0;
         total_ff        <= '0;
         samples_ff      <= '0;
         points_ff       <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         first_ff        <= first_in;
         last_ff         <= last_in;
         incr_ff         <= incr_in;
         settle_ff       <= settle_in;
         sample_len_ff   <= sample_len_in;
         active_ff       <= active_in;
         duty_ff         <= duty_in;
         window_start_ff <= window_start_in;
         total_ff        <= total_in;
         samples_ff      <= samples_in;
         points_ff       <= points_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      mode_ff    <= mode_in;
      now_ff     <= now_in;
      rpm_ff     <= rpm_in;
      elapsed_ff <= elapsed_in;
      win_end_ff <= win_end_in;
      res_ff     <= res_in;
      rsp_ff     <= rsp_in;
   end

   // ports
   assign req_stall       = (state_ff != S_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_drive_valid = rsp_ff.drive_valid;
   assign rsp_drive_pwm   = rsp_ff.drive_pwm;
   assign rsp_point_valid = rsp_ff.point_valid;
   assign rsp_point_index = rsp_ff.point_index;
   assign rsp_point_pwm   = rsp_ff.point_pwm;
   assign rsp_point_rpm   = rsp_ff.point_rpm;
   assign rsp_done_res    = rsp_ff.done_res;
   assign rsp_busy_res    = rsp_ff.busy_res;

   // checks
   a_accept_holds_off: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken but sequencer did not leave idle");

   a_div_only_in_div: assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> (state_ff == S_DIV))
      else $error("divider running outside its wait state");

   a_points_bounded: assert property (@(posedge clock) disable iff (reset)
      points_ff <= PW'(MAX_POINTS))
      else $error("point count passed the map size");

   a_point_with_drive: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_point_valid) |-> rsp_drive_valid)
      else $error("point reported without an applied drive");

endmodule

`default_nettype wire

// ===== tb/tb_pwm_sweep_rpm_calibrator_core.sv =====
module tb_pwm_sweep_rpm_calibrator_core;
   import pwmc_pkg::*;

   // request mode codes
   localparam logic MODE_UPDATE = 1'b0;
   localparam logic MODE_START  = 1'b1;

   // index with no register behind it
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;

   localparam int MAP_DEPTH  = MAX_POINTS_DEF;
   localparam int LONG_HOLD  = 300;
   localparam int RUN_LIMIT  = 3_000_000;

   typedef struct packed {
      logic              mode;
      logic [TIME_W-1:0] now_ms;
      logic [RPM_W-1:0]  rpm;
   } sweep_item_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_mode = 1'b0;
   logic [TIME_W-1:0]     req_now_ms = '0;
   logic [RPM_W-1:0]      req_rpm_sample = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_drive_valid;
   logic [DUTY_W-1:0]     rsp_drive_pwm;
   logic                  rsp_point_valid;
   logic [IDX_W-1:0]      rsp_point_index;
   logic [DUTY_W-1:0]     rsp_point_pwm;
   logic [RPM_W-1:0]      rsp_point_rpm;
   logic                  rsp_done_res;
   logic                  rsp_busy_res;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   pwm_sweep_rpm_calibrator_core dut (.*);

   always #5 clock = ~clock;

   // sweep registers as the block should hold them
   logic [DUTY_W-1:0] cfg_first  = PWM_FIRST_RST;
   logic [DUTY_W-1:0] cfg_last   = PWM_LAST_RST;
   logic [DUTY_W-1:0] cfg_step   = PWM_INCREMENT_RST;
   logic [MS_W-1:0]   cfg_settle = SETTLE_MS_RST;
   logic [MS_W-1:0]   cfg_sample = SAMPLE_MS_RST;

   // sweep state
   logic                  run_on     = 1'b0;
   logic [DUTY_EXT_W-1:0] duty_cur   = 9'd30;
   logic [TIME_W-1:0]     win_t0     = '0;
   logic [SUM_W-1:0]      rpm_acc    = '0;
   logic [CNT_W-1:0]      n_acc      = '0;
   logic [6:0]            points_cnt = '0;

   sweep_item_type pending_items[$];
   res_type        expected_res[$];
   int             mismatches = 0;
   int             cycle_cnt = 0;

   // shared pacing controls
   bit idle_on = 1'b1;
   bit hold_req = 1'b0;

   // sweep step: response for one request, updates the sweep state
   function automatic res_type calib_step(input sweep_item_type it);
      res_type          r;
      logic [TIME_W-1:0] elapsed;
      logic [TIME_W-1:0] window_end;
      logic [SUM_W-1:0]  quot;
      r = '0;
      if (it.mode == MODE_START) begin
         run_on = 1'b1;
         duty_cur = {1'b0, cfg_first};
         points_cnt = '0;
         win_t0 = it.now_ms;
         rpm_acc = '0;
         n_acc = '0;
         r.busy_res = 1'b1;
         return r;
      end
      if (!run_on)
         return r;
      r.drive_valid = 1'b1;
      r.drive_pwm = duty_cur[DUTY_W-1:0];
      r.busy_res = 1'b1;
      elapsed = it.now_ms - win_t0;
      window_end = 32'(cfg_settle) + 32'(cfg_sample);
      if (elapsed < 32'(cfg_settle))
         return r;
      if (elapsed < window_end) begin
         // count stops at its ceiling and the sum freezes with it
         if (n_acc != 16'hFFFF) begin
            rpm_acc = rpm_acc + 34'(it.rpm);
            n_acc = n_acc + 1'b1;
         end
         return r;
      end
      // both windows over: emit the point unless the map is full
      if (points_cnt < MAP_DEPTH) begin
         quot = (n_acc == 0) ? '0 : rpm_acc / 34'(n_acc);
         r.point_valid = 1'b1;
         r.point_index = points_cnt[IDX_W-1:0];
         r.point_pwm = duty_cur[DUTY_W-1:0];
         r.point_rpm = quot[RPM_W-1:0];
         points_cnt = points_cnt + 1'b1;
      end
      duty_cur = duty_cur + 9'(cfg_step);
      if (duty_cur > 9'(cfg_last)) begin
         run_on = 1'b0;
         r.drive_pwm = '0;
         r.done_res = 1'b1;
         r.busy_res = 1'b0;
         return r;
      end
      win_t0 = it.now_ms;
      rpm_acc = '0;
      n_acc = '0;
      return r;
   endfunction

   task automatic log_mismatch(input string what, input res_type want, input res_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("%s: want drv=%0d/%0d pt=%0d idx=%0d pwm=%0d rpm=%0d done=%0d busy=%0d",
                  what, want.drive_valid, want.drive_pwm, want.point_valid, want.point_index,
                  want.point_pwm, want.point_rpm, want.done_res, want.busy_res);
      if (mismatches <= 10)
         $display("   got drv=%0d/%0d pt=%0d idx=%0d pwm=%0d rpm=%0d done=%0d busy=%0d",
                  got.drive_valid, got.drive_pwm, got.point_valid, got.point_index,
                  got.point_pwm, got.point_rpm, got.done_res, got.busy_res);
   endtask

   // request driver
   sweep_item_type cur_item = '0;
   bit             offer = 1'b0;
   int             send_gap = 0;

   always @(posedge clock) begin
      if (reset) begin
         offer = 1'b0;
         send_gap = 0;
      end else begin
         // beat taken: predict its response
         if (offer && !req_stall) begin
            expected_res.push_back(calib_step(cur_item));
            offer = 1'b0;
         end
         if (!offer) begin
            if (send_gap > 0)
               send_gap--;
            else if (pending_items.size() > 0) begin
               if (idle_on && $urandom_range(0, 9) == 0)
                  send_gap = $urandom_range(1, 18) - 1;
               else begin
                  cur_item = pending_items.pop_front();
                  offer = 1'b1;
               end
            end
         end
      end
      req_valid <= offer;
      req_mode <= cur_item.mode;
      req_now_ms <= cur_item.now_ms;
      req_rpm_sample <= cur_item.rpm;
   end

   // response monitor and receiver stall
   always @(posedge clock) begin : rsp_monitor
      res_type got;
      res_type want;
      bit      stall_next;
      int      hold_left;
      int      gap_left;
      if (reset) begin
         stall_next = 1'b0;
         hold_left = 0;
         gap_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_drive_valid, rsp_drive_pwm, rsp_point_valid, rsp_point_index,
                   rsp_point_pwm, rsp_point_rpm, rsp_done_res, rsp_busy_res};
            if (expected_res.size() == 0)
               log_mismatch("response with nothing pending", '0, got);
            else begin
               want = expected_res.pop_front();
               if (got !== want)
                  log_mismatch("response mismatch", want, got);
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            stall_next = 1'b1;
         end else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = LONG_HOLD - 1;
            stall_next = 1'b1;
         end else if (gap_left > 0) begin
            gap_left--;
            stall_next = 1'b1;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            gap_left = $urandom_range(1, 18) - 1;
            stall_next = 1'b1;
         end else
            stall_next = 1'b0;
      end
      rsp_stall <= stall_next;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt == RUN_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic push_item(input logic mode, input logic [TIME_W-1:0] now,
                            input logic [RPM_W-1:0] rpm);
      sweep_item_type it;
      it.mode = mode;
      it.now_ms = now;
      it.rpm = rpm;
      pending_items.push_back(it);
   endtask

   // register write; 8-bit registers get junk in the unused upper byte
   task automatic set_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= (idx <= CSR_PWM_INCREMENT) ? {8'($urandom), val[7:0]} : val;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_PWM_FIRST:     cfg_first = val[7:0];
         CSR_PWM_LAST:      cfg_last = val[7:0];
         CSR_PWM_INCREMENT: cfg_step = val[7:0];
         CSR_SETTLE_MS:     cfg_settle = val;
         CSR_SAMPLE_MS:     cfg_sample = val;
         default: ;
      endcase
   endtask

   task automatic set_sweep(input logic [7:0] first, input logic [7:0] last,
                            input logic [7:0] step, input logic [15:0] settle,
                            input logic [15:0] sample);
      set_reg(CSR_PWM_FIRST, 16'(first));
      set_reg(CSR_PWM_LAST, 16'(last));
      set_reg(CSR_PWM_INCREMENT, 16'(step));
      set_reg(CSR_SETTLE_MS, settle);
      set_reg(CSR_SAMPLE_MS, sample);
      @(negedge clock);
   endtask

   // sender waits until every response is back
   task automatic wait_drained();
      @(negedge clock);
      while (pending_items.size() != 0 || offer || expected_res.size() != 0)
         @(negedge clock);
   endtask

   function automatic logic [7:0] pick_duty();
      case ($urandom_range(0, 7))
         0: return 8'd0;
         1: return 8'd255;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_window();
      case ($urandom_range(0, 11))
         0: return 16'd0;
         1: return 16'hFFFF;
         2: return 16'($urandom);
         default: return 16'($urandom_range(0, 40));
      endcase
   endfunction

   function automatic logic [RPM_W-1:0] pick_rpm();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return RPM_W'($urandom);
      endcase
   endfunction

   // random sweep runs under a random register setting
   task automatic random_phase(input int n_items, input bit with_hold);
      logic [7:0]        first;
      logic [7:0]        last;
      logic [7:0]        step;
      logic [TIME_W-1:0] t;
      int                span;
      int                since_start;
      int                run_len;
      first = pick_duty();
      last = $urandom_range(0, 3) == 0 ? pick_duty() : 8'($urandom_range(first, 255));
      case ($urandom_range(0, 19))
         0: step = 8'd0;
         1: step = 8'd255;
         2: step = 8'd1;
         default: step = 8'($urandom_range(1, 40));
      endcase
      set_sweep(first, last, step, pick_window(), pick_window());
      span = int'(cfg_settle) + int'(cfg_sample);
      t = $urandom;
      since_start = 0;
      run_len = 0;
      for (int i = 0; i < n_items; i++) begin
         if (i == 0 || since_start >= run_len || $urandom_range(0, 49) == 0) begin
            if ($urandom_range(0, 1) == 1)
               t = $urandom;
            push_item(MODE_START, t, pick_rpm());
            since_start = 0;
            run_len = $urandom_range(10, 80);
         end else begin
            case ($urandom_range(0, 19))
               0: t = $urandom;
               1, 2: ;
               default: t = t + 32'($urandom_range(0, span / 3 + 1));
            endcase
            push_item(MODE_UPDATE, t, pick_rpm());
            since_start++;
         end
      end
      // receiver holds off while the sender keeps offering
      if (with_hold)
         hold_req = 1'b1;
      wait_drained();
   endtask

   initial begin : stimulus
      logic [TIME_W-1:0] t;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // register defaults: idle updates, wrapping timestamps, restart mid-run
      t = 32'hFFFF_FA00;
      push_item(MODE_UPDATE, 32'hFFFF_FFFF, 18'h3FFFF);
      push_item(MODE_UPDATE, 32'h0, 18'h0);
      push_item(MODE_START, t, 18'h3FFFF);
      push_item(MODE_UPDATE, t + 32'd1499, 18'h12345);
      push_item(MODE_UPDATE, t + 32'd1500, 18'h3FFFF);
      push_item(MODE_UPDATE, t + 32'd1999, 18'h1);
      push_item(MODE_UPDATE, t + 32'd2000, 18'h0);
      push_item(MODE_UPDATE, t + 32'd3500, 18'h15555);
      push_item(MODE_START, 32'h0, 18'h2AAAA);
      push_item(MODE_UPDATE, 32'd2000, 18'h3FFFF);
      wait_drained();

      // first above last with no increment: one step then done
      set_sweep(8'd255, 8'd0, 8'd0, 16'd0, 16'd3);
      t = 32'h8000_0000;
      push_item(MODE_START, t, 18'h0);
      push_item(MODE_UPDATE, t, 18'h15555);
      push_item(MODE_UPDATE, t + 32'd3, 18'h2AAAA);
      push_item(MODE_UPDATE, t + 32'd4, 18'h3FFFF);
      wait_drained();

      // widest windows, largest increment, duty past the 8-bit range
      set_reg(CSR_UNUSED, 16'($urandom));
      set_sweep(8'd0, 8'd255, 8'd255, 16'hFFFF, 16'hFFFF);
      t = 32'h1234_5678;
      push_item(MODE_START, t, 18'h3FFFF);
      push_item(MODE_UPDATE, t + 32'd65534, 18'h3FFFF);
      push_item(MODE_UPDATE, t + 32'd65535, 18'h3FFFF);
      push_item(MODE_UPDATE, t + 32'd131069, 18'h0);
      push_item(MODE_UPDATE, t + 32'd131070, 18'h0);
      push_item(MODE_UPDATE, t + 32'd262140, 18'h0);
      wait_drained();

      // fixed duty fills the map, then a restart begins at index zero
      set_sweep(8'd100, 8'd200, 8'd0, 16'd0, 16'd1);
      t = $urandom;
      push_item(MODE_START, t, pick_rpm());
      for (int i = 0; i < 70; i++) begin
         push_item(MODE_UPDATE, t, pick_rpm());
         t = t + 32'd1;
         push_item(MODE_UPDATE, t, pick_rpm());
      end
      push_item(MODE_START, t, pick_rpm());
      push_item(MODE_UPDATE, t, pick_rpm());
      push_item(MODE_UPDATE, t + 32'd1, pick_rpm());
      wait_drained();

      // random runs, with idling on both sides when the phase draws it
      for (int p = 0; p < 6; p++) begin
         idle_on = (p == 1) || ($urandom_range(0, 3) != 0);
         random_phase(215, p == 1);
      end

      // closing part without idling
      idle_on = 1'b0;
      random_phase(215, 1'b0);

      repeat (50) @(posedge clock);
      mismatches += expected_res.size();
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
